// ===== src/crsg_pkg.sv =====
// Shared types and constants for the Catmull-Rom segment generator.
// No dependencies; imported by the front end, the evaluator and the top level.
`timescale 1ns / 1ps

package crsg_pkg;

    // Configuration register map.
    localparam int CFG_ADDR_W = 3;
    typedef logic [CFG_ADDR_W-1:0] cfg_addr_t;

    localparam cfg_addr_t REG_POINT_BEFORE = 3'd0;
    localparam cfg_addr_t REG_POINT_START  = 3'd1;
    localparam cfg_addr_t REG_POINT_END    = 3'd2;
    localparam cfg_addr_t REG_POINT_AFTER  = 3'd3;
    localparam cfg_addr_t REG_T_BEGIN      = 3'd4;
    localparam cfg_addr_t REG_T_INCREMENT  = 3'd5;

    // Sample mode code: a set mode bit multiplies the incoming sample by the curve.
    localparam logic MODE_MODULATE = 1'b1;

    // Flags that travel with each input word, listed from the highest bit down;
    // mode is bit 0.
    typedef struct packed {
        logic restart;
        logic mode;
    } item_flags_t;

endpackage

// ===== src/crsg_fifo.sv =====
// Short first-in first-out queue between the front end and the evaluator.
// Self-contained; no package needed.
`timescale 1ns / 1ps

module crsg_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             push;
    logic             pop;

    assign in_ready  = (count_reg != CNT_W'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

`ifndef SYNTHESIS
    a_full_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == CNT_W'(DEPTH)) |-> !in_ready)
        else $error("queue accepts a word while full");

    a_push_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("queue count missed a push");

    a_pop_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && !push) |=> (count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("queue count missed a pop");
`endif

endmodule

// ===== src/crsg_front.sv =====
// Front end: accepts sample slots, tracks the curve position and queues work.
// Depends on crsg_pkg for the input flag struct.
`timescale 1ns / 1ps

module crsg_front
    import crsg_pkg::*;
#(
    parameter int SAMPLE_BITS = 16,
    parameter int FRAC_BITS   = 16,
    localparam int QW         = FRAC_BITS + SAMPLE_BITS + 2
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  item_flags_t            in_flags,
    input  logic [SAMPLE_BITS-1:0] in_sample,
    input  logic [FRAC_BITS:0]     t_begin,
    input  logic [FRAC_BITS:0]     t_increment,
    output logic                   push_valid,
    input  logic                   push_ready,
    output logic [QW-1:0]          push_data
);

    localparam logic [FRAC_BITS:0] T_ONE = {1'b1, {FRAC_BITS{1'b0}}};

    logic [FRAC_BITS:0]   position_reg;
    logic [FRAC_BITS:0]   position_next;
    logic [FRAC_BITS:0]   t_use;
    logic [FRAC_BITS+1:0] t_sum;

    // A restart reloads the position before this word; a start beyond one is clamped.
    always_comb begin
        if (in_flags.restart) begin
            t_use = (t_begin > T_ONE) ? T_ONE : t_begin;
        end else begin
            t_use = position_reg;
        end
        t_sum         = {1'b0, t_use} + {1'b0, t_increment};
        position_next = (t_sum > {1'b0, T_ONE}) ? T_ONE : t_sum[FRAC_BITS:0];
    end

    assign push_valid = in_valid;
    assign in_ready   = push_ready;
    assign push_data  = {in_flags.mode, in_sample, t_use};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            position_reg <= '0;
        end else if (in_valid && push_ready) begin
            position_reg <= position_next;
        end
    end

endmodule

// ===== src/crsg_back.sv =====
// Evaluator: Horner evaluation of the cubic on one shared multiplier, then
// replace or modulate with rounding and saturation. Depends on crsg_pkg.
`timescale 1ns / 1ps

module crsg_back
    import crsg_pkg::*;
#(
    parameter int SAMPLE_BITS = 16,
    parameter int FRAC_BITS   = 16,
    localparam int QW         = FRAC_BITS + SAMPLE_BITS + 2
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic signed [SAMPLE_BITS-1:0] point_before,
    input  logic signed [SAMPLE_BITS-1:0] point_start,
    input  logic signed [SAMPLE_BITS-1:0] point_end,
    input  logic signed [SAMPLE_BITS-1:0] point_after,
    input  logic                          q_valid,
    output logic                          q_ready,
    input  logic [QW-1:0]                 q_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [SAMPLE_BITS-1:0]        out_sample
);

    // Accumulator width: twice the curve value stays within 24 sample ranges.
    localparam int S  = SAMPLE_BITS;
    localparam int F  = FRAC_BITS;
    localparam int AW = S + 6;
    localparam int PW = AW + F + 2;
    localparam int MW = S + AW;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_H2   = 2'd1;
    localparam logic [1:0] ST_H3   = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    localparam logic signed [PW-1:0] HALF_T = {{(PW - F){1'b0}}, 1'b1, {(F - 1){1'b0}}};
    localparam logic signed [MW-1:0] S_MAX  = {{(MW - S + 1){1'b0}}, {(S - 1){1'b1}}};
    localparam logic signed [MW-1:0] S_MIN  = ~S_MAX;
    localparam logic signed [MW-1:0] HALF_S = {{(MW - S){1'b0}}, 1'b1, {(S - 1){1'b0}}};
    localparam logic signed [AW-1:0] ONE_A  = {{(AW - 1){1'b0}}, 1'b1};

    logic signed [AW-1:0] p0e, p1e, p2e, p3e;
    logic signed [AW-1:0] c0, c1, c2, c3;

    logic [1:0]           state_reg, state_next;
    logic signed [AW-1:0] acc_reg, acc_next;
    logic [F:0]           t_reg;
    logic signed [S-1:0]  sample_reg;
    logic                 mode_reg;
    logic [S-1:0]         out_reg;
    logic                 out_valid_reg;

    logic [F:0]           q_t;
    logic signed [AW-1:0] acc_op;
    logic [F:0]           t_op;
    logic signed [AW-1:0] coef;
    logic signed [PW-1:0] prod;
    logic signed [PW-1:0] prod_rnd;

    logic signed [MW-1:0] mprod;
    logic signed [MW-1:0] mrnd;
    logic signed [AW-1:0] rsum;
    logic signed [AW-1:0] rep;
    logic signed [MW-1:0] val;
    logic [S-1:0]         val_sat;
    logic                 out_load;

    assign p0e = AW'(point_before);
    assign p1e = AW'(point_start);
    assign p2e = AW'(point_end);
    assign p3e = AW'(point_after);

    assign c0 = p1e + p1e;
    assign c1 = p2e - p0e;
    assign c2 = (p0e <<< 1) - (p1e <<< 2) - p1e + (p2e <<< 2) - p3e;
    assign c3 = (p1e <<< 1) + p1e - (p2e <<< 1) - p2e + p3e - p0e;

    assign q_t     = q_data[F:0];
    assign q_ready = (state_reg == ST_IDLE);

    // One multiply-add step of Horner's rule per cycle; the first step starts
    // directly from the queue head.
    always_comb begin
        case (state_reg)
            ST_IDLE: begin
                acc_op = c3;
                t_op   = q_t;
                coef   = c2;
            end
            ST_H2: begin
                acc_op = acc_reg;
                t_op   = t_reg;
                coef   = c1;
            end
            default: begin
                acc_op = acc_reg;
                t_op   = t_reg;
                coef   = c0;
            end
        endcase
    end

    assign prod     = acc_op * $signed({1'b0, t_op});
    assign prod_rnd = prod + HALF_T;
    assign acc_next = AW'(prod_rnd >>> F) + coef;

    // Modulate rounds the magnitude half away from zero; replace rounds half up.
    assign mprod = sample_reg * acc_reg;
    assign mrnd  = (mprod < 0) ? (mprod + S_MAX) : (mprod + HALF_S);
    assign rsum  = acc_reg + ONE_A;
    assign rep   = rsum >>> 1;

    always_comb begin
        if (mode_reg == MODE_MODULATE) begin
            val = mrnd >>> S;
        end else begin
            val = MW'(rep);
        end
        if (val > S_MAX) begin
            val_sat = S_MAX[S-1:0];
        end else if (val < S_MIN) begin
            val_sat = S_MIN[S-1:0];
        end else begin
            val_sat = val[S-1:0];
        end
    end

    assign out_load = (state_reg == ST_OUT) && (!out_valid_reg || out_ready);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    state_next = ST_H2;
                end
            end
            ST_H2:   state_next = ST_H3;
            ST_H3:   state_next = ST_OUT;
            ST_OUT: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && q_valid) begin
            t_reg      <= q_t;
            sample_reg <= $signed(q_data[F+S:F+1]);
            mode_reg   <= q_data[QW-1];
            acc_reg    <= acc_next;
        end else if (state_reg == ST_H2 || state_reg == ST_H3) begin
            acc_reg <= acc_next;
        end
        if (out_load) begin
            out_reg <= val_sat;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_sample = out_reg;

`ifndef SYNTHESIS
    a_pop_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE && q_valid) |=> (state_reg == ST_H2))
        else $error("evaluator did not start on a queued word");

    a_valid_from_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_OUT))
        else $error("result shown outside the output step");

    a_out_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> (out_valid_reg && state_reg == ST_IDLE))
        else $error("output step did not register a result");
`endif

endmodule

// ===== src/catmull_rom_segment_generator_top.sv =====
// Top level of the Catmull-Rom segment generator: configuration registers,
// front end, work queue and evaluator. Depends on crsg_pkg and the src modules.
//
//   channel | direction | tdata              | tuser
//   s_      | in        | in_sample          | [0] mode, [1] restart
//   m_      | out       | out_sample         | -
//   cfg_    | in        | register write     | -
//
// In the evaluator each word goes through three Horner multiply-add steps on
// one shared multiplier and then one output step; that multiplier sets the rate.
// The front end takes words while the 2-entry queue has room, so the input
// side runs ahead of the evaluator. Results sit in an output register and the
// evaluator only holds when that register is full and not taken.
// Reset is synchronous and active low and needs no clearing pass.
`timescale 1ns / 1ps

module catmull_rom_segment_generator_top
    import crsg_pkg::*;
#(
    parameter int SAMPLE_BITS = 16,
    parameter int FRAC_BITS   = 16,
    localparam int DATA_W     = ((SAMPLE_BITS + 7) / 8) * 8,
    localparam int CFG_W      = (SAMPLE_BITS > FRAC_BITS + 1) ? SAMPLE_BITS : FRAC_BITS + 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [DATA_W-1:0] s_tdata,   // in_sample
    input  logic [1:0]        s_tuser,   // mode, restart
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [DATA_W-1:0] m_tdata,   // out_sample
    input  logic              cfg_wen,
    input  cfg_addr_t         cfg_addr,
    input  logic [CFG_W-1:0]  cfg_wdata
);

    localparam int QW = FRAC_BITS + SAMPLE_BITS + 2;

    logic signed [SAMPLE_BITS-1:0] point_before_reg;
    logic signed [SAMPLE_BITS-1:0] point_start_reg;
    logic signed [SAMPLE_BITS-1:0] point_end_reg;
    logic signed [SAMPLE_BITS-1:0] point_after_reg;
    logic [FRAC_BITS:0]            t_begin_reg;
    logic [FRAC_BITS:0]            t_increment_reg;

    item_flags_t          in_flags;
    logic                 push_valid;
    logic                 push_ready;
    logic [QW-1:0]        push_data;
    logic                 q_valid;
    logic                 q_ready;
    logic [QW-1:0]        q_data;
    logic [SAMPLE_BITS-1:0] out_sample;

    // Writes to indexes past the register list are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            point_before_reg <= '0;
            point_start_reg  <= '0;
            point_end_reg    <= '0;
            point_after_reg  <= '0;
            t_begin_reg      <= '0;
            t_increment_reg  <= '0;
        end else if (cfg_wen) begin
            case (cfg_addr)
                REG_POINT_BEFORE: point_before_reg <= $signed(cfg_wdata[SAMPLE_BITS-1:0]);
                REG_POINT_START:  point_start_reg  <= $signed(cfg_wdata[SAMPLE_BITS-1:0]);
                REG_POINT_END:    point_end_reg    <= $signed(cfg_wdata[SAMPLE_BITS-1:0]);
                REG_POINT_AFTER:  point_after_reg  <= $signed(cfg_wdata[SAMPLE_BITS-1:0]);
                REG_T_BEGIN:      t_begin_reg      <= cfg_wdata[FRAC_BITS:0];
                REG_T_INCREMENT:  t_increment_reg  <= cfg_wdata[FRAC_BITS:0];
                default: begin
                end
            endcase
        end
    end

    assign in_flags = item_flags_t'(s_tuser);

    crsg_front #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .FRAC_BITS   (FRAC_BITS)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_flags    (in_flags),
        .in_sample   (s_tdata[SAMPLE_BITS-1:0]),
        .t_begin     (t_begin_reg),
        .t_increment (t_increment_reg),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_data   (push_data)
    );

    crsg_fifo #(
        .WIDTH (QW),
        .DEPTH (2)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (push_valid),
        .in_ready  (push_ready),
        .in_data   (push_data),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_data  (q_data)
    );

    crsg_back #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .FRAC_BITS   (FRAC_BITS)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .point_before (point_before_reg),
        .point_start  (point_start_reg),
        .point_end    (point_end_reg),
        .point_after  (point_after_reg),
        .q_valid      (q_valid),
        .q_ready      (q_ready),
        .q_data       (q_data),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_sample   (out_sample)
    );

    assign m_tdata = DATA_W'(out_sample);

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for catmull_rom_segment_generator_top: directed and random
// sample words, register settings and handshake stalls, checked against a curve predictor.
// Depends on crsg_pkg and the RTL under src.
`timescale 1ns / 1ps

module testbench;
    import crsg_pkg::*;

    localparam int SETTLE_CYCLES  = 16;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 3000;

    localparam logic               MODE_REPLACE     = ~MODE_MODULATE;
    localparam cfg_addr_t          UNMAPPED_REG     = 3'd6;
    localparam cfg_addr_t          UNMAPPED_REG_TOP = 3'd7;
    localparam logic signed [15:0] SAMPLE_MAX       = 16'sh7FFF;
    localparam logic signed [15:0] SAMPLE_MIN       = 16'sh8000;
    localparam logic [16:0]        T_ONE            = 17'h10000;
    localparam logic [16:0]        T_ALL_ONES       = 17'h1FFFF;

    // Tracks the segment registers and the running curve position, and holds the
    // output samples that accepted input words are expected to produce.
    class curve_scoreboard;
        logic signed [15:0] p_before, p_start, p_end, p_after;
        logic [16:0]        t_begin, t_step, position;
        logic signed [15:0] expected_samples[$];
        int                 mismatches;

        function new();
            p_before   = '0;
            p_start    = '0;
            p_end      = '0;
            p_after    = '0;
            t_begin    = '0;
            t_step     = '0;
            position   = '0;
            mismatches = 0;
        endfunction

        function void write_reg(cfg_addr_t addr, logic [16:0] data);
            case (addr)
                REG_POINT_BEFORE: p_before = data[15:0];
                REG_POINT_START:  p_start  = data[15:0];
                REG_POINT_END:    p_end    = data[15:0];
                REG_POINT_AFTER:  p_after  = data[15:0];
                REG_T_BEGIN:      t_begin  = data;
                REG_T_INCREMENT:  t_step   = data;
                default: ;
            endcase
        endfunction

        function logic signed [15:0] curve_sample(item_flags_t flags, logic signed [15:0] smp);
            longint             p0, p1, p2, p3, c0, c1, c2, c3, t, a, x, mag, q;
            bit                 neg;
            logic signed [15:0] y;
            logic [17:0]        next_pos;
            p0 = p_before;
            p1 = p_start;
            p2 = p_end;
            p3 = p_after;
            c0 = 2 * p1;
            c1 = p2 - p0;
            c2 = 2 * p0 - 5 * p1 + 4 * p2 - p3;
            c3 = -p0 + 3 * p1 - 3 * p2 + p3;
            if (flags.restart)
                position = (t_begin > T_ONE) ? T_ONE : t_begin;
            t = position;
            // Horner steps, each product rounded half up back to sample units;
            // the sum is twice the curve value.
            a = c3;
            a = ((a * t + 32768) >>> 16) + c2;
            a = ((a * t + 32768) >>> 16) + c1;
            a = ((a * t + 32768) >>> 16) + c0;
            if (flags.mode == MODE_MODULATE) begin
                x   = smp;
                neg = (x < 0) != (a < 0);
                mag = (x < 0 ? -x : x) * (a < 0 ? -a : a);
                q   = (mag + 32768) >>> 16;
                if (neg)
                    y = (q > 32768) ? SAMPLE_MIN : 16'(-q);
                else
                    y = (q > 32767) ? SAMPLE_MAX : 16'(q);
            end else begin
                q = (a + 1) >>> 1;
                if (q > 32767)
                    y = SAMPLE_MAX;
                else if (q < -32768)
                    y = SAMPLE_MIN;
                else
                    y = 16'(q);
            end
            next_pos = position + t_step;
            position = (next_pos > T_ONE) ? T_ONE : next_pos[16:0];
            return y;
        endfunction

        function void note_word(item_flags_t flags, logic signed [15:0] smp);
            expected_samples.push_back(curve_sample(flags, smp));
        endfunction

        function void check_sample(logic signed [15:0] got);
            logic signed [15:0] want;
            if (expected_samples.size() == 0) begin
                $error("out_sample: expected no word, actual %0d", got);
                mismatches++;
            end else begin
                want = expected_samples.pop_front();
                if (got !== want) begin
                    $error("out_sample: expected %0d, actual %0d", want, got);
                    mismatches++;
                end
            end
        endfunction

        function int pending();
            return expected_samples.size();
        endfunction
    endclass

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata   = '0;
    logic [1:0]  s_tuser   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;
    logic        cfg_wen   = 1'b0;
    cfg_addr_t   cfg_addr  = '0;
    logic [16:0] cfg_wdata = '0;

    bit              steady           = 1'b0;
    bit              hold_off_request = 1'b0;
    int              idle_cycles      = 0;
    curve_scoreboard curve;

    catmull_rom_segment_generator_top DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wen   (cfg_wen),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #5 aclk = ~aclk;

    // Result side: checks each accepted word, then picks the next tready. A
    // hold-off request blocks the output for a long stretch so the input backs up.
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready)
                curve.check_sample(m_tdata);
            @(negedge aclk);
            if (hold_off_request) begin
                hold_off_request = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready = 1'b0;
            end else if (steady) begin
                m_tready = 1'b1;
            end else begin
                m_tready = ($urandom_range(0, 99) >= 25);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("testbench failed");
                $finish;
            end
        end
    end

    task automatic write_reg(input cfg_addr_t addr, input logic [16:0] data);
        cfg_wen   = 1'b1;
        cfg_addr  = addr;
        cfg_wdata = data;
        curve.write_reg(addr, data);
        @(negedge aclk);
        cfg_wen = 1'b0;
    endtask

    // Offers one word after an optional random gap; returns at the falling edge
    // after acceptance with tvalid still high.
    task automatic send_word(input item_flags_t flags, input logic signed [15:0] smp);
        while (!steady && $urandom_range(0, 99) < 25) begin
            s_tvalid = 1'b0;
            s_tdata  = 16'($urandom_range(0, 65535));
            s_tuser  = 2'($urandom_range(0, 3));
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = smp;
        s_tuser  = flags;
        do @(posedge aclk); while (!s_tready);
        curve.note_word(flags, smp);
        @(negedge aclk);
    endtask

    task automatic settle();
        s_tvalid = 1'b0;
        while (curve.pending() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    function automatic logic [16:0] pick_point();
        case ($urandom_range(0, 3))
            0:       return {1'($urandom_range(0, 1)), SAMPLE_MAX};
            1:       return {1'($urandom_range(0, 1)), SAMPLE_MIN};
            default: return 17'($urandom_range(0, T_ALL_ONES));
        endcase
    endfunction

    task automatic random_setup();
        logic [16:0] start_pos, step;
        case ($urandom_range(0, 4))
            0:       start_pos = '0;
            1:       start_pos = T_ONE;
            2:       start_pos = 17'($urandom_range(T_ONE + 1, T_ALL_ONES));
            default: start_pos = 17'($urandom_range(0, T_ONE));
        endcase
        // Mostly small steps so that a phase walks across the whole segment.
        case ($urandom_range(0, 7))
            0:       step = '0;
            1:       step = T_ONE;
            2:       step = 17'($urandom_range(0, T_ALL_ONES));
            3:       step = 17'($urandom_range(0, T_ONE));
            default: step = 17'($urandom_range(1, 4096));
        endcase
        write_reg(REG_POINT_BEFORE, pick_point());
        write_reg(REG_POINT_START, pick_point());
        write_reg(REG_POINT_END, pick_point());
        write_reg(REG_POINT_AFTER, pick_point());
        write_reg(REG_T_BEGIN, start_pos);
        write_reg(REG_T_INCREMENT, step);
        if ($urandom_range(0, 3) == 0)
            write_reg($urandom_range(0, 1) ? UNMAPPED_REG : UNMAPPED_REG_TOP,
                      17'($urandom_range(0, T_ALL_ONES)));
    endtask

    initial begin
        item_flags_t        fl;
        logic signed [15:0] smp;
        int                 count;
        curve = new();
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Straight out of reset with no restart: position stays at zero.
        send_word('{restart: 1'b0, mode: MODE_REPLACE}, 16'sh1234);
        send_word('{restart: 1'b0, mode: MODE_MODULATE}, SAMPLE_MAX);
        settle();

        // Alternating extreme points; a start beyond one is clamped to one.
        write_reg(REG_POINT_BEFORE, {1'b1, SAMPLE_MIN});
        write_reg(REG_POINT_START, {1'b0, SAMPLE_MAX});
        write_reg(REG_POINT_END, {1'b1, SAMPLE_MIN});
        write_reg(REG_POINT_AFTER, {1'b0, SAMPLE_MAX});
        write_reg(REG_T_BEGIN, T_ALL_ONES);
        write_reg(REG_T_INCREMENT, '0);
        write_reg(UNMAPPED_REG, T_ALL_ONES);
        write_reg(UNMAPPED_REG_TOP, T_ONE);
        send_word('{restart: 1'b1, mode: MODE_REPLACE}, 16'sh0000);
        send_word('{restart: 1'b0, mode: MODE_MODULATE}, SAMPLE_MAX);
        send_word('{restart: 1'b0, mode: MODE_MODULATE}, SAMPLE_MIN);
        send_word('{restart: 1'b0, mode: MODE_MODULATE}, -16'sd1);
        send_word('{restart: 1'b0, mode: MODE_MODULATE}, 16'sh0000);
        settle();

        // Opposite extremes walked across the segment in quarter steps.
        write_reg(REG_POINT_BEFORE, {1'b0, SAMPLE_MAX});
        write_reg(REG_POINT_START, {1'b0, SAMPLE_MIN});
        write_reg(REG_POINT_END, {1'b0, SAMPLE_MAX});
        write_reg(REG_POINT_AFTER, {1'b0, SAMPLE_MIN});
        write_reg(REG_T_BEGIN, '0);
        write_reg(REG_T_INCREMENT, 17'h04000);
        send_word('{restart: 1'b1, mode: MODE_REPLACE}, SAMPLE_MIN);
        send_word('{restart: 1'b0, mode: MODE_REPLACE}, SAMPLE_MAX);
        send_word('{restart: 1'b0, mode: MODE_MODULATE}, SAMPLE_MIN);
        send_word('{restart: 1'b0, mode: MODE_MODULATE}, SAMPLE_MAX);
        send_word('{restart: 1'b0, mode: MODE_REPLACE}, 16'sh5555);
        send_word('{restart: 1'b0, mode: MODE_REPLACE}, 16'shAAAA);
        settle();

        // Position overflow: the step carries the position past one.
        write_reg(REG_POINT_BEFORE, 17'h01000);
        write_reg(REG_POINT_START, 17'h1C000);
        write_reg(REG_POINT_END, 17'h06000);
        write_reg(REG_POINT_AFTER, 17'h0F000);
        write_reg(REG_T_BEGIN, 17'd50000);
        write_reg(REG_T_INCREMENT, 17'd30000);
        send_word('{restart: 1'b1, mode: MODE_MODULATE}, 16'sh4000);
        send_word('{restart: 1'b0, mode: MODE_REPLACE}, 16'sh0000);
        send_word('{restart: 1'b0, mode: MODE_MODULATE}, 16'shC000);
        send_word('{restart: 1'b1, mode: MODE_REPLACE}, 16'sh0001);
        send_word('{restart: 1'b0, mode: MODE_MODULATE}, SAMPLE_MAX);
        settle();

        for (int phase = 0; phase < 10; phase++) begin
            random_setup();
            steady = (phase == 5);
            if (phase == 3)
                hold_off_request = 1'b1;
            count = $urandom_range(55, 85);
            for (int k = 0; k < count; k++) begin
                fl.restart = ($urandom_range(0, 9) == 0);
                fl.mode    = 1'($urandom_range(0, 1));
                case ($urandom_range(0, 9))
                    0:       smp = SAMPLE_MAX;
                    1:       smp = SAMPLE_MIN;
                    2:       smp = '0;
                    default: smp = 16'($urandom_range(0, 65535));
                endcase
                send_word(fl, smp);
            end
            settle();
            steady = 1'b0;
        end

        if (curve.mismatches == 0 && curve.pending() == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
